>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants and types for the text console writer: screen geometry,
// character codes, blank cell and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

  localparam int COLUMNS = 80;
  localparam int ROWS    = 24;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int ROW_W   = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_LAST  = ADDR_W'(CELLS - COLUMNS - 1);
  localparam logic [ADDR_W-1:0] BLANK_BASE = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam logic [15:0] BLANK_CELL = 16'h0020;

  localparam logic       REQ_PUT  = 1'b0;
  localparam logic       REQ_READ = 1'b1;

  localparam logic       REG_BG   = 1'b0;
  localparam logic       REG_FG   = 1'b1;

  localparam logic [3:0] BG_RESET = 4'h0;
  localparam logic [3:0] FG_RESET = 4'hF;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_COPY,
    ST_DRAIN,
    ST_BLANK,
    ST_FINISH
  } st_t;

endpackage

`default_nettype wire

>>> rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell console: screen store, cursor, scroll-up and cell readback,
// sequenced over a single-port cell memory and one shared address counter.
// ----------------------------------------------------------------------------
// Sequencing: a put without scroll goes from idle straight to the finish state,
// a read through a cell-read state first; a put that scrolls copies the rows up,
// drains the last copy and blanks the bottom row, one memory copy or blank per
// cycle through the shared address counter. One request at a time is taken,
// and again only once the sequencer idles; the finish state holds until the
// result port is free. Reset: synchronous; a clearing pass blanks the screen
// before the first request is taken. Config writes are taken always.
`default_nettype none

module text_console_writer
  import tcw_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [4:0]  in_read_row,
  input  wire logic [6:0]  in_read_col,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [10:0]      out_cursor_pos,
  output logic [15:0]      out_cell_value,
  output logic             out_scrolled,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  st_t               state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [ADDR_W-1:0] wr_addr_r, wr_addr_nxt;
  logic              copy_vld_r, copy_vld_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [3:0]        bg_r, bg_nxt;
  logic [3:0]        fg_r, fg_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [15:0]       res_cell_r, res_cell_nxt;
  logic              res_scr_r, res_scr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [10:0]       out_pos_r, out_pos_nxt;
  logic [15:0]       out_cell_r, out_cell_nxt;
  logic              out_scr_r, out_scr_nxt;

  logic [15:0]       mem [CELLS];
  logic [15:0]       rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [ADDR_W-1:0] mem_raddr;
  logic [15:0]       mem_wdata;

  logic              req_acc;
  logic              out_free;
  logic              cfg_wr;
  logic              is_bs, is_nl, is_prt;
  logic              row_last, col_last;
  logic [COL_W-1:0]  col_put;
  logic [ROW_W-1:0]  row_put;
  logic              scroll_req;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;
  logic [10:0]       cur_pos;

  assign req_acc  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_FG) ? {28'd0, fg_r} : {28'd0, bg_r};

  assign out_valid      = out_valid_r;
  assign out_cursor_pos = out_pos_r;
  assign out_cell_value = out_cell_r;
  assign out_scrolled   = out_scr_r;

  assign cur_addr    = ADDR_W'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign cur_pos     = 11'(32'(cur_row_r) * COLUMNS + 32'(cur_col_r));
  assign rd_in_range = (32'(in_read_row) < ROWS) && (32'(in_read_col) < COLUMNS);
  assign rd_addr     = ADDR_W'(32'(in_read_row) * COLUMNS + 32'(in_read_col));

  // put decode: cursor move and scroll request
  always_comb begin
    is_bs    = (in_char_code == CH_BS);
    is_nl    = (in_char_code == CH_NL);
    is_prt   = (in_char_code >= CH_SPACE) && (in_char_code <= CH_DEL);
    row_last = (cur_row_r == ROW_LAST);
    col_last = (cur_col_r == COL_LAST);
    col_put    = cur_col_r;
    row_put    = cur_row_r;
    scroll_req = 1'b0;
    if (is_bs) begin
      if (cur_col_r != '0) begin
        col_put = cur_col_r - 1'b1;
      end else if (cur_row_r != '0) begin
        col_put = COL_LAST;
        row_put = cur_row_r - 1'b1;
      end
    end else if (is_nl || (is_prt && col_last)) begin
      col_put = '0;
      if (row_last) begin
        scroll_req = 1'b1;
      end else begin
        row_put = cur_row_r + 1'b1;
      end
    end else if (is_prt) begin
      col_put = cur_col_r + 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == REQ_READ) state_nxt = ST_READ;
          else if (scroll_req)     state_nxt = ST_COPY;
          else                     state_nxt = ST_FINISH;
        end
      end
      ST_READ:  state_nxt = ST_FINISH;
      ST_COPY: begin
        if (addr_r == COPY_LAST) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_BLANK;
      ST_BLANK: begin
        if (addr_r == LAST_ADDR) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and memory control
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    addr_nxt      = addr_r;
    wr_addr_nxt   = wr_addr_r;
    copy_vld_nxt  = copy_vld_r;
    cur_col_nxt   = cur_col_r;
    cur_row_nxt   = cur_row_r;
    rd_ok_nxt     = rd_ok_r;
    res_cell_nxt  = res_cell_r;
    res_scr_nxt   = res_scr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_pos_nxt   = out_pos_r;
    out_cell_nxt  = out_cell_r;
    out_scr_nxt   = out_scr_r;
    bg_nxt        = bg_r;
    fg_nxt        = fg_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = BLANK_CELL;
    mem_raddr     = addr_r + ROW_STRIDE;

    if (cfg_wr) begin
      if (paddr[2] == REG_BG) bg_nxt = pwdata[3:0];
      else                    fg_nxt = pwdata[3:0];
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        addr_nxt = addr_r + 1'b1;
      end
      ST_IDLE: begin
        if (req_acc) begin
          res_cell_nxt = '0;
          res_scr_nxt  = 1'b0;
          addr_nxt     = '0;
          copy_vld_nxt = 1'b0;
          if (in_func == REQ_READ) begin
            mem_raddr = rd_addr;
            rd_ok_nxt = rd_in_range;
          end else begin
            mem_we      = is_prt;
            mem_waddr   = cur_addr;
            mem_wdata   = {bg_r, fg_r, in_char_code};
            cur_col_nxt = col_put;
            cur_row_nxt = row_put;
            res_scr_nxt = scroll_req;
          end
        end
      end
      ST_READ: begin
        res_cell_nxt = rd_ok_r ? rd_data_r : '0;
      end
      ST_COPY: begin
        mem_we       = copy_vld_r;
        mem_waddr    = wr_addr_r;
        mem_wdata    = rd_data_r;
        wr_addr_nxt  = addr_r;
        copy_vld_nxt = 1'b1;
        addr_nxt     = addr_r + 1'b1;
      end
      ST_DRAIN: begin
        mem_we    = 1'b1;
        mem_waddr = wr_addr_r;
        mem_wdata = rd_data_r;
        addr_nxt  = BLANK_BASE;
      end
      ST_BLANK: begin
        mem_we    = 1'b1;
        mem_wdata = {4'd0, bg_r, CH_SPACE};
        addr_nxt  = addr_r + 1'b1;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = cur_pos;
          out_cell_nxt  = res_cell_r;
          out_scr_nxt   = res_scr_r;
        end
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      addr_r      <= '0;
      copy_vld_r  <= 1'b0;
      cur_col_r   <= '0;
      cur_row_r   <= '0;
      bg_r        <= BG_RESET;
      fg_r        <= FG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      copy_vld_r  <= copy_vld_nxt;
      cur_col_r   <= cur_col_nxt;
      cur_row_r   <= cur_row_nxt;
      bg_r        <= bg_nxt;
      fg_r        <= fg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r  <= wr_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    res_cell_r <= res_cell_nxt;
    res_scr_r  <= res_scr_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cell_r <= out_cell_nxt;
    out_scr_r  <= out_scr_nxt;
  end

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_row_r) < ROWS)
    else $error("cursor row beyond last row");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_col_r) < COLUMNS)
    else $error("cursor column beyond last column");

  a_read_next: assert property (@(posedge clk) disable iff (!rst_n)
    (req_acc && (in_func == REQ_READ)) |=> (state_r == ST_READ))
    else $error("read request did not start a cell read");

  a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_scr_r) |-> (out_pos_r == 11'((ROWS - 1) * COLUMNS)))
    else $error("scroll result not at start of last row");

  a_no_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_COPY) || (state_r == ST_BLANK) || (state_r == ST_CLEAR))
      |-> !in_ready)
    else $error("request taken during a memory sweep");

endmodule

`default_nettype wire

>>> bench/tcw_console_checker.sv
// ----------------------------------------------------------------------------
// tcw_console_checker
// Watches the request, result and register ports of the text console writer.
// Keeps its own copy of the screen, the cursor and both colours, works out
// the result of every accepted request and compares each returned result,
// field by field, with the oldest outstanding one. Register readback is
// checked against the colours it holds.
// ----------------------------------------------------------------------------
module tcw_console_checker
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_func,
  input  logic [7:0]  in_char_code,
  input  logic [4:0]  in_read_row,
  input  logic [6:0]  in_read_col,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [10:0] out_cursor_pos,
  input  logic [15:0] out_cell_value,
  input  logic        out_scrolled,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,

  output int          mismatches,
  output int          outstanding,
  output int          results_checked,
  output int          scrolls_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [15:0] cell_value;
    logic        scrolled;
  } console_result_t;

  localparam logic [2:0] BG_ADDR = {REG_BG, 2'b00};
  localparam logic [2:0] FG_ADDR = {REG_FG, 2'b00};

  logic [15:0]      screen [CELLS];
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [3:0]       bg_colour;
  logic [3:0]       fg_colour;

  console_result_t  pending_results[$];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns  mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  function automatic console_result_t apply_request(logic func, logic [7:0] code,
                                                    logic [4:0] rrow, logic [6:0] rcol);
    console_result_t res;
    res = '0;
    if (func == REQ_READ) begin
      if (rrow < ROWS && rcol < COLUMNS)
        res.cell_value = screen[rrow * COLUMNS + rcol];
    end else begin
      if (code == CH_BS) begin
        if (cur_col != '0) begin
          cur_col--;
        end else if (cur_row != '0) begin
          cur_col = COL_LAST;
          cur_row--;
        end
      end else if (code == CH_NL) begin
        cur_col = '0;
        cur_row++;
      end else if (code >= CH_SPACE && code <= CH_DEL) begin
        screen[cur_row * COLUMNS + cur_col] = {bg_colour, fg_colour, code};
        if (cur_col != COL_LAST) begin
          cur_col++;
        end else begin
          cur_col = '0;
          cur_row++;
        end
      end
      if (cur_row == ROWS) begin
        for (int i = 0; i < CELLS - COLUMNS; i++)
          screen[i] = screen[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
          screen[i] = {4'h0, bg_colour, CH_SPACE};
        cur_row = ROW_LAST;
        res.scrolled = 1'b1;
      end
    end
    res.cursor_pos = 11'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    console_result_t next;
    if (!rst_n) begin
      foreach (screen[i]) screen[i] = BLANK_CELL;
      cur_col         = '0;
      cur_row         = '0;
      bg_colour       = BG_RESET;
      fg_colour       = FG_RESET;
      pending_results.delete();
      mismatches      = 0;
      results_checked = 0;
      scrolls_seen    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", out_cursor_pos, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_cursor_pos !== want.cursor_pos)
            report_mismatch("cursor_pos", out_cursor_pos, want.cursor_pos);
          if (out_cell_value !== want.cell_value)
            report_mismatch("cell_value", out_cell_value, want.cell_value);
          if (out_scrolled !== want.scrolled)
            report_mismatch("scrolled", out_scrolled, want.scrolled);
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        next = apply_request(in_func, in_char_code, in_read_row, in_read_col);
        if (next.scrolled) scrolls_seen++;
        pending_results.push_back(next);
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == BG_ADDR) bg_colour = pwdata[3:0];
          else if (paddr == FG_ADDR) fg_colour = pwdata[3:0];
        end else if (paddr == BG_ADDR) begin
          if (prdata !== {28'h0, bg_colour})
            report_mismatch("background_color readback", prdata, {28'h0, bg_colour});
        end else if (paddr == FG_ADDR) begin
          if (prdata !== {28'h0, fg_colour})
            report_mismatch("letter_color readback", prdata, {28'h0, fg_colour});
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

>>> bench/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives the text console writer with a short directed run over the
// character classes, cursor wraps and out-of-screen reads, then with lines of
// random text, backspaces, noise codes and cell reads under several colour
// settings, enough to scroll the screen many times. Both channels idle and
// stall at random; the checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 110;
  localparam int IDLE_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = 50;

  localparam logic [2:0] BG_ADDR = {REG_BG, 2'b00};
  localparam logic [2:0] FG_ADDR = {REG_FG, 2'b00};

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;

  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic        in_func      = REQ_PUT;
  logic [7:0]  in_char_code = '0;
  logic [4:0]  in_read_row  = '0;
  logic [6:0]  in_read_col  = '0;

  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [10:0] out_cursor_pos;
  logic [15:0] out_cell_value;
  logic        out_scrolled;

  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          outstanding;
  int          results_checked;
  int          scrolls_seen;

  int          burst_left   = 0;
  int          requests_sent = 0;
  int          useful_items = 0;
  int          idle_cycles  = 0;

  text_console_writer u_dut (.*);

  tcw_console_checker u_checker (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_request(logic func, logic [7:0] code, logic [4:0] row, logic [6:0] col);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(5, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_func      <= func;
    in_char_code <= code;
    in_read_row  <= row;
    in_read_col  <= col;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    requests_sent++;
  endtask

  task automatic put_char(logic [7:0] code);
    send_request(REQ_PUT, code, 5'($urandom), 7'($urandom));
    useful_items++;
  endtask

  task automatic put_noise();
    logic [7:0] code;
    if ($urandom_range(0, 1)) begin
      code = 8'($urandom_range(8'h80, 8'hFF));
    end else begin
      do code = 8'($urandom_range(0, 31)); while (code == CH_BS || code == CH_NL);
    end
    send_request(REQ_PUT, code, 5'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(logic [4:0] row, logic [6:0] col);
    send_request(REQ_READ, 8'($urandom), row, col);
    useful_items++;
  endtask

  task automatic read_random_cell();
    if ($urandom_range(0, 99) < 85)
      read_cell(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLUMNS - 1)));
    else
      read_cell(5'($urandom), 7'($urandom));
  endtask

  task automatic send_text_line();
    int len;
    int shape;
    int pick;
    shape = $urandom_range(0, 99);
    if (shape < 40) len = $urandom_range(0, 4);
    else if (shape < 85) len = $urandom_range(5, 25);
    else len = $urandom_range(26, 170);
    for (int k = 0; k < len; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) read_random_cell();
      else if (pick < 20) put_noise();
      else if (pick < 26) repeat ($urandom_range(1, 3)) put_char(CH_BS);
      put_char(8'($urandom_range(CH_SPACE, CH_DEL)));
    end
    if ($urandom_range(0, 9) != 0) put_char(CH_NL);
    if ($urandom_range(0, 9) == 0) put_char(CH_BS);
  endtask

  task automatic register_access(logic wr, logic [2:0] addr, logic [3:0] val);
    logic [31:0] data;
    data      = $urandom();
    data[3:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  // hold off the result side in patterns, with one long squeeze
  initial begin : result_sink
    int  mode;
    int  left;
    int  hold;
    int  seen;
    bit  squeezed;
    bit  rdy;
    mode = 0;
    left = 0;
    hold = 0;
    seen = 0;
    squeezed = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (!squeezed && seen >= 500) begin
        squeezed = 1'b1;
        hold = 400;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 128);
      end
      left--;
      if (hold > 0) begin
        hold--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = ((left % 5) < 2);
        endcase
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("tb_text_console_writer NOT OK");
      $finish;
    end
  end

  initial begin : stimulus
    logic [3:0] bg;
    logic [3:0] fg;
    int         target;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset colours, character classes, cursor wraps, reads off the screen
    read_cell(5'd0, 7'd0);
    put_char(CH_BS);
    send_request(REQ_PUT, 8'h00, 5'h1F, 7'h7F);
    send_request(REQ_PUT, 8'h1F, 5'h00, 7'h00);
    send_request(REQ_PUT, 8'h80, 5'h15, 7'h2A);
    send_request(REQ_PUT, 8'hFF, 5'h0A, 7'h55);
    put_char(CH_SPACE);
    put_char(CH_DEL);
    put_char(8'h41);
    put_char(CH_NL);
    put_char(CH_BS);
    put_char(8'h5A);
    put_char(CH_BS);
    put_char(CH_BS);
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'(COLUMNS - 1));
    read_cell(5'(ROWS - 1), 7'(COLUMNS - 1));
    read_cell(5'(ROWS), 7'd0);
    read_cell(5'h1F, 7'h7F);
    read_cell(5'd0, 7'(COLUMNS));
    read_cell(5'(ROWS - 1), 7'h7F);
    put_char(CH_NL);
    send_request(REQ_PUT, 8'h09, 5'h00, 7'h00);
    send_request(REQ_PUT, 8'h0D, 5'h1F, 7'h7F);

    for (int p = 0; p < N_PHASES; p++) begin
      wait_for_idle();
      case (p)
        0: begin
          bg = 4'hF;
          fg = 4'h0;
        end
        1: begin
          bg = 4'h0;
          fg = 4'hF;
        end
        2: begin
          bg = 4'hF;
          fg = 4'hF;
        end
        3: begin
          bg = 4'h0;
          fg = 4'h0;
        end
        default: begin
          bg = 4'($urandom);
          fg = 4'($urandom);
        end
      endcase
      register_access(1'b1, BG_ADDR, bg);
      register_access(1'b1, FG_ADDR, fg);
      register_access(1'b0, BG_ADDR, 4'h0);
      register_access(1'b0, FG_ADDR, 4'h0);
      // drop to the bottom row so that later lines scroll
      if (p == 0) repeat (ROWS) put_char(CH_NL);
      target = useful_items + PHASE_ITEMS;
      while (useful_items < target) send_text_line();
    end

    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d requests (%0d text, control or read) under %0d colour settings",
             requests_sent, useful_items, N_PHASES + 1);
    $display("%0d results checked, %0d screen scrolls, %0d mismatches",
             results_checked, scrolls_seen, mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_text_console_writer OK");
    else
      $display("tb_text_console_writer NOT OK");
    $finish;
  end

endmodule
